>>> hw/rtl/pareto_nondominated_filter_defines.svh
// ----------------------------------------------------------------------------
// Pareto filter assertion macros
// Shared concurrent assertion forms for the Pareto filter RTL.
// ----------------------------------------------------------------------------
`ifndef PARETO_NONDOMINATED_FILTER_DEFINES_SVH
`define PARETO_NONDOMINATED_FILTER_DEFINES_SVH

// same-cycle implication
`define PNF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pnf_pkg.sv
// ----------------------------------------------------------------------------
// Pareto filter package
// Widths and default sizes shared by the Pareto filter modules.
// ----------------------------------------------------------------------------
package pnf_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_OBJ_DEF    = 8;
	localparam int OBJ_W          = 32;
	localparam int OBJ_PORTS      = 8;
	localparam int IDX_W          = 6;
	localparam int CFG_W          = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

endpackage

>>> hw/rtl/pareto_nondominated_filter.sv
// ----------------------------------------------------------------------------
// Pareto non-dominated filter
// Points enter on in_valid/in_ready, one transfer per cycle while loading.
// The transfer with last_point set closes the set; in_ready then drops while
// each stored point i is read back and compared against every stored point
// over the single store read port, through fetch, latch, sweep and decide.
// Survivors leave on out_valid/out_ready in input order, last_result on the
// final one, held in an output register; a stalled receiver halts the sweep.
// Points beyond the store size are dropped and flag overflow on every result
// of the set. objective_count is written over cfg_valid/cfg_ready (always
// ready) and is sampled when the last point transfers. Reset empties the set
// and sets objective_count to 2; the store holds no reset state.
// ----------------------------------------------------------------------------
`include "pareto_nondominated_filter_defines.svh"

module pareto_nondominated_filter #(
	parameter int MAX_POINTS     = pnf_pkg::MAX_POINTS_DEF,
	parameter int MAX_OBJECTIVES = pnf_pkg::MAX_OBJ_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pnf_pkg::CFG_W-1:0]        objective_count,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_0,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_1,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_2,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_3,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_4,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_5,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_6,
	input  logic signed [pnf_pkg::OBJ_W-1:0] objective_7,
	input  logic                             last_point,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pnf_pkg::IDX_W-1:0]        point_index,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_0,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_1,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_2,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_3,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_4,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_5,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_6,
	output logic signed [pnf_pkg::OBJ_W-1:0] out_objective_7,
	output logic                             overflow,
	output logic                             last_result
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int OW = pnf_pkg::OBJ_W;
	localparam int DW = MAX_OBJECTIVES * OW;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_LATCH,
		ST_SWEEP,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	state_t                      state_q;
	logic [pnf_pkg::CFG_W-1:0]   cfg_q;
	logic [pnf_pkg::CFG_W-1:0]   k_q;
	logic [pnf_pkg::CFG_W-1:0]   k_sat;
	logic [CW-1:0]               cnt_q;
	logic                        ovf_q;
	logic [CW-1:0]               i_q;
	logic [CW-1:0]               i_nxt;
	logic [CW-1:0]               j_q;
	logic [CW-1:0]               j_s1;
	logic                        dom_q;
	logic [DW-1:0]               cur_q;
	logic                        pend_valid_q;
	logic [pnf_pkg::IDX_W-1:0]   pend_idx_q;
	logic [DW-1:0]               pend_data_q;
	logic                        out_valid_q;
	logic [pnf_pkg::IDX_W-1:0]   out_idx_q;
	logic [DW-1:0]               out_data_q;
	logic                        out_ovf_q;
	logic                        out_last_q;

	logic                        in_fire;
	logic                        out_free;
	logic                        wr_en;
	logic [IW-1:0]               rd_addr;
	logic [DW-1:0]               rd_data;
	logic [DW-1:0]               wr_data;
	logic                        dom_hit;
	logic                        survive;
	logic                        go;
	logic signed [OW-1:0]        in_obj [pnf_pkg::OBJ_PORTS];
	logic signed [OW-1:0]        out_obj [pnf_pkg::OBJ_PORTS];

	assign in_obj[0] = objective_0;
	assign in_obj[1] = objective_1;
	assign in_obj[2] = objective_2;
	assign in_obj[3] = objective_3;
	assign in_obj[4] = objective_4;
	assign in_obj[5] = objective_5;
	assign in_obj[6] = objective_6;
	assign in_obj[7] = objective_7;

	for (genvar n = 0; n < pnf_pkg::OBJ_PORTS; n++) begin : g_obj
		if (n < MAX_OBJECTIVES) begin : g_used
			assign wr_data[n*OW +: OW] = in_obj[n];
			assign out_obj[n]          = $signed(out_data_q[n*OW +: OW]);
		end else begin : g_zero
			assign out_obj[n] = '0;
		end
	end

	assign out_objective_0 = out_obj[0];
	assign out_objective_1 = out_obj[1];
	assign out_objective_2 = out_obj[2];
	assign out_objective_3 = out_obj[3];
	assign out_objective_4 = out_obj[4];
	assign out_objective_5 = out_obj[5];
	assign out_objective_6 = out_obj[6];
	assign out_objective_7 = out_obj[7];

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ST_LOAD);
	assign in_fire     = in_valid & in_ready;
	assign out_valid   = out_valid_q;
	assign point_index = out_idx_q;
	assign overflow    = out_ovf_q;
	assign last_result = out_last_q;
	assign out_free    = ~out_valid_q | out_ready;
	assign wr_en       = in_fire & (cnt_q < CW'(MAX_POINTS));
	assign i_nxt       = CW'(i_q + 1'b1);
	assign survive     = ~dom_q;
	assign go          = ~survive | ~pend_valid_q | out_free;

	always_comb begin
		if (cfg_q == '0) begin
			k_sat = pnf_pkg::CFG_W'(1);
		end else if (cfg_q > pnf_pkg::CFG_W'(MAX_OBJECTIVES)) begin
			k_sat = pnf_pkg::CFG_W'(MAX_OBJECTIVES);
		end else begin
			k_sat = cfg_q;
		end
	end

	always_comb begin
		case (state_q)
			ST_FETCH: begin
				rd_addr = i_q[IW-1:0];
			end
			ST_LATCH: begin
				rd_addr = '0;
			end
			default: begin
				rd_addr = j_q[IW-1:0];
			end
		endcase
	end

	pnf_store #(
		.DEPTH (MAX_POINTS),
		.WIDTH (DW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pnf_cmp #(
		.MAX_OBJECTIVES (MAX_OBJECTIVES)
	) u_cmp (
		.cand      (rd_data),
		.cur       (cur_q),
		.obj_cnt   (k_q),
		.dominates (dom_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cfg_q        <= pnf_pkg::CFG_RESET;
			k_q          <= pnf_pkg::CFG_RESET;
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			j_s1         <= '0;
			dom_q        <= 1'b0;
			cur_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			pend_data_q  <= '0;
			out_valid_q  <= 1'b0;
			out_idx_q    <= '0;
			out_data_q   <= '0;
			out_ovf_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= objective_count;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (wr_en) begin
							cnt_q <= CW'(cnt_q + 1'b1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_point) begin
							k_q     <= k_sat;
							i_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					cur_q   <= rd_data;
					dom_q   <= 1'b0;
					j_s1    <= '0;
					j_q     <= CW'(1);
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (dom_hit && (j_s1 != i_q)) begin
						dom_q <= 1'b1;
					end
					j_s1 <= j_q;
					j_q  <= CW'(j_q + 1'b1);
					if (j_s1 == CW'(cnt_q - 1'b1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (survive && pend_valid_q && out_free) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= pend_idx_q;
						out_data_q  <= pend_data_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= 1'b0;
					end
					if (survive && go) begin
						pend_valid_q <= 1'b1;
						pend_idx_q   <= pnf_pkg::IDX_W'(i_q);
						pend_data_q  <= cur_q;
					end
					if (go) begin
						i_q     <= i_nxt;
						state_q <= (i_nxt == cnt_q) ? ST_FLUSH : ST_FETCH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_idx_q    <= pend_idx_q;
						out_data_q   <= pend_data_q;
						out_ovf_q    <= ovf_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						cnt_q        <= '0;
						ovf_q        <= 1'b0;
						state_q      <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	`PNF_ASSERT_IMPLY(a_load_no_pend, clk, arst_n, state_q == ST_LOAD, !pend_valid_q,
		"pending result while loading")
	`PNF_ASSERT_IMPLY(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_POINTS),
		"point count above capacity")
	`PNF_ASSERT_IMPLY(a_idx_range, clk, arst_n,
		state_q != ST_LOAD && state_q != ST_FLUSH, i_q < cnt_q, "point index past set size")
	`PNF_ASSERT_NEXT(a_flush_last, clk, arst_n, state_q == ST_FLUSH && out_free,
		out_valid && last_result, "flush did not present last result")

endmodule

>>> hw/rtl/pnf_store.sv
// ----------------------------------------------------------------------------
// Pareto filter point store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pnf_store #(
	parameter int DEPTH = pnf_pkg::MAX_POINTS_DEF,
	parameter int WIDTH = pnf_pkg::MAX_OBJ_DEF * pnf_pkg::OBJ_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/pnf_cmp.sv
// ----------------------------------------------------------------------------
// Pareto filter dominance compare
// Flags when the candidate point dominates the current point (minimize).
// ----------------------------------------------------------------------------
module pnf_cmp #(
	parameter int MAX_OBJECTIVES = pnf_pkg::MAX_OBJ_DEF
) (
	input  logic [MAX_OBJECTIVES*pnf_pkg::OBJ_W-1:0] cand,
	input  logic [MAX_OBJECTIVES*pnf_pkg::OBJ_W-1:0] cur,
	input  logic [pnf_pkg::CFG_W-1:0]                obj_cnt,
	output logic                                     dominates
);

	always_comb begin
		logic worse;
		logic better;
		logic act;
		logic signed [pnf_pkg::OBJ_W-1:0] a;
		logic signed [pnf_pkg::OBJ_W-1:0] b;
		worse  = 1'b0;
		better = 1'b0;
		for (int n = 0; n < MAX_OBJECTIVES; n++) begin
			act = pnf_pkg::CFG_W'(n) < obj_cnt;
			a   = $signed(cand[n*pnf_pkg::OBJ_W +: pnf_pkg::OBJ_W]);
			b   = $signed(cur[n*pnf_pkg::OBJ_W +: pnf_pkg::OBJ_W]);
			worse  = worse  | (act & (a > b));
			better = better | (act & (a < b));
		end
		dominates = better & ~worse;
	end

endmodule
